// ===== rtl/core/cfd_pkg.sv =====
// Shared constants, types and the sync string lookup for the checksum deframer.
// Used by the framing logic in the top level and by the payload readout unit.
`default_nettype none

package cfd_pkg;

	// Largest payload length that a frame may carry.
	localparam int MAX_LEN = 32;
	// Address width of the payload memory.
	localparam int ADDR_W = $clog2(MAX_LEN);
	// Width of the length and byte counters.
	localparam int LEN_W = 6;
	// Length of the sync command string.
	localparam logic [LEN_W-1:0] SYNC_LEN = 6'd8;
	// Header byte value after reset.
	localparam logic [7:0] HEADER_RESET = 8'h7E;

	// Payload memory write request from the framing logic.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} cfd_wr_t;

	// Result request issued when a checksum byte completes a frame.
	typedef struct packed {
		logic             start;   // verified payload, read it out
		logic [LEN_W-1:0] len;
		logic             sync;
		logic             single;  // one result without data
		logic             ok;
	} cfd_cmd_t;

	// Characters of the eight-byte sync command string, one per position.
	function automatic logic [7:0] sync_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h53;
			3'd1: c = 8'h59;
			3'd2: c = 8'h4E;
			3'd3: c = 8'h43;
			3'd4: c = 8'h5F;
			3'd5: c = 8'h43;
			3'd6: c = 8'h4D;
			3'd7: c = 8'h44;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfd_readout.sv =====
// Payload memory, readout sequencer and output register of the deframer.
// Depends on cfd_pkg for the memory geometry and the request types.
`default_nettype none

module cfd_readout import cfd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfd_wr_t    wr,
	input  wire cfd_cmd_t   cmd,
	output logic            busy,
	input  wire logic       out_stall,
	output logic            out_valid,
	output logic [7:0]      payload_byte,
	output logic            has_data,
	output logic            frame_ok,
	output logic            is_sync_command,
	output logic            last
);

	logic [7:0]        mem [MAX_LEN];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [LEN_W-1:0]  rd_left_q;
	logic              pend_q;
	logic              pend_last_q;
	logic              sync_q;
	logic              out_free;
	logic              rd_en;
	logic              load_pend;

	// The output register can take a new transaction when empty or draining.
	assign out_free  = !out_valid || !out_stall;
	assign load_pend = pend_q && out_free;
	assign rd_en     = (rd_left_q != '0) && (!pend_q || out_free);
	assign busy      = (rd_left_q != '0) || pend_q;

	// Payload memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr_q];
		end
	end

	// Readout sequencer: one read in flight, held until the output takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_left_q   <= '0;
			rd_addr_q   <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			sync_q      <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_left_q <= cmd.len;
				rd_addr_q <= '0;
				sync_q    <= cmd.sync;
			end else if (rd_en) begin
				rd_left_q <= rd_left_q - 1'b1;
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			if (rd_en) begin
				pend_q      <= 1'b1;
				pend_last_q <= (rd_left_q == 6'd1);
			end else if (load_pend) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_pend || cmd.single) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_pend) begin
			payload_byte    <= rd_data_q;
			has_data        <= 1'b1;
			frame_ok        <= 1'b1;
			is_sync_command <= sync_q;
			last            <= pend_last_q;
		end else if (cmd.single) begin
			payload_byte    <= 8'h00;
			has_data        <= 1'b0;
			frame_ok        <= cmd.ok;
			is_sync_command <= 1'b0;
			last            <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	// New frames and memory writes arrive only while no readout runs.
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start || cmd.single || wr.en) |-> !busy)
		else $error("request while readout is busy");

	// A single result never lands on an occupied output register.
	a_single_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.single |-> out_free)
		else $error("single result overwrites pending output");

	// Read data waiting for the output is kept until it is loaded.
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && !out_free) |=> (pend_q && $stable(rd_data_q)))
		else $error("pending read data lost");

	// The readout never runs past the payload memory.
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_left_q <= LEN_W'(MAX_LEN))
		else $error("readout count beyond payload limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/checksum_frame_deframer_unit.sv =====
// An error or empty-frame result reaches the output register the cycle after its checksum
// byte; a verified payload passes the readout counters, memory read register and output
// register before its first byte shows. Input takes one byte per cycle unless in_stall;
// a verified frame reads out one byte per cycle unless out_stall; input waits meanwhile.
// Reset clears framing state and the header byte to 0x7E; the payload memory is not cleared.
`default_nettype none

module checksum_frame_deframer_unit import cfd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            has_data,
	output logic            frame_ok,
	output logic            is_sync_command,
	output logic            last
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_LENGTH  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_CHECK   = 2'd3;

	logic [7:0]       header_q;
	logic [1:0]       phase_q, phase_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [LEN_W-1:0] idx_q, idx_n;
	logic [7:0]       sum_q, sum_n;
	logic             sync_q, sync_n;
	logic             accept;
	logic             busy;
	cfd_wr_t          wr;
	cfd_cmd_t         cmd;

	// Input is held off during readout and while the output register is stuck.
	assign in_stall = busy || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;

	// Header byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_wr_en) begin
			header_q <= cfg_wr_data;
		end
	end

	// Framing state machine.
	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		idx_n   = idx_q;
		sum_n   = sum_q;
		sync_n  = sync_q;
		wr      = '0;
		cmd     = '0;
		if (accept) begin
			if (rx_byte == header_q) begin
				phase_n = PH_LENGTH;
				sum_n   = 8'h00;
			end else begin
				case (phase_q)
					PH_LENGTH: begin
						if (rx_byte > 8'(MAX_LEN)) begin
							phase_n = PH_HEADER;
						end else begin
							len_n   = rx_byte[LEN_W-1:0];
							idx_n   = '0;
							sync_n  = 1'b1;
							phase_n = (rx_byte == 8'h00) ? PH_CHECK : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						wr.en   = 1'b1;
						wr.addr = idx_q[ADDR_W-1:0];
						wr.data = rx_byte;
						if (idx_q >= SYNC_LEN || sync_char(idx_q[2:0]) != rx_byte) begin
							sync_n = 1'b0;
						end
						sum_n = sum_q + rx_byte;
						idx_n = idx_q + 1'b1;
						if (idx_n >= len_q) begin
							phase_n = PH_CHECK;
						end
					end
					PH_CHECK: begin
						if (sum_q == rx_byte) begin
							if (len_q == '0) begin
								cmd.single = 1'b1;
								cmd.ok     = 1'b1;
							end else begin
								cmd.start = 1'b1;
								cmd.len   = len_q;
								cmd.sync  = sync_q && (len_q == SYNC_LEN);
							end
						end else begin
							cmd.single = 1'b1;
							cmd.ok     = 1'b0;
						end
						phase_n = PH_HEADER;
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end
	end

	// Framing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			len_q   <= '0;
			idx_q   <= '0;
			sum_q   <= 8'h00;
			sync_q  <= 1'b1;
		end else begin
			phase_q <= phase_n;
			len_q   <= len_n;
			idx_q   <= idx_n;
			sum_q   <= sum_n;
			sync_q  <= sync_n;
		end
	end

	// Payload memory and result output.
	cfd_readout u_readout (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr              (wr),
		.cmd             (cmd),
		.busy            (busy),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.payload_byte    (payload_byte),
		.has_data        (has_data),
		.frame_ok        (frame_ok),
		.is_sync_command (is_sync_command),
		.last            (last)
	);

endmodule

`default_nettype wire
